// ----- design/pts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the buzzer melody sequencer.
// ----------------------------------------------------------------------------
package pts_pkg;

  // field widths
  localparam int CLK_W  = 27;
  localparam int FREQ_W = 16;
  localparam int IDX_W  = 9;
  localparam int VOL_W  = 10;
  localparam int CFG_IDX_W = 3;

  // serial divider widths
  localparam int DIV_NW = 27;
  localparam int DIV_DW = 17;
  localparam int DIV_CW = 6;

  // request types
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_CMD   = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // command bytes
  localparam logic [7:0] CMD_SLOT0  = 8'h6d;  // m
  localparam logic [7:0] CMD_SLOT1  = 8'h6e;  // n
  localparam logic [7:0] CMD_SLOT2  = 8'h70;  // p
  localparam logic [7:0] CMD_VOL_UP = 8'h48;  // H
  localparam logic [7:0] CMD_VOL_DN = 8'h4c;  // L
  localparam logic [7:0] CMD_PAUSE  = 8'h53;  // S
  localparam logic [7:0] CMD_RESUME = 8'h50;  // P

  // configuration register indexes
  localparam logic [2:0] CFG_SYS_CLK = 3'd0;
  localparam logic [2:0] CFG_S0_BASE = 3'd1;
  localparam logic [2:0] CFG_S0_CNT  = 3'd2;
  localparam logic [2:0] CFG_S1_BASE = 3'd3;
  localparam logic [2:0] CFG_S1_CNT  = 3'd4;
  localparam logic [2:0] CFG_S2_BASE = 3'd5;
  localparam logic [2:0] CFG_S2_CNT  = 3'd6;

  // volume
  localparam logic [VOL_W-1:0] VOL_RESET = 10'd30;
  localparam logic [VOL_W-1:0] VOL_MAX   = 10'd1000;
  localparam logic [VOL_W-1:0] VOL_STEP  = 10'd5;
  localparam logic [IDX_W-1:0] CNT_MAX   = 9'd256;
  localparam logic [DIV_DW-1:0] DUTY_DIV = 17'd2000;

  // duty scaling by reciprocal multiply, operand below 2**DUTY_W
  localparam int DUTY_W  = 26;
  localparam int DUTY_SH = DUTY_W + 11;
  localparam logic [26:0] DUTY_RCP =
    27'(((64'd1 << DUTY_SH) + 64'(DUTY_DIV) - 64'd1) / 64'(DUTY_DIV));

  // arithmetic steps of one tone load
  typedef enum logic [2:0] {
    OP_CLK_F,
    OP_PERIOD,
    OP_CLK_PRE,
    OP_PER_F,
    OP_DUTY
  } pts_op_t;

  // controller to datapath
  typedef struct packed {
    logic    take;
    logic    exec;
    logic    ent;
    logic    div_start;
    logic    div_store;
    pts_op_t div_op;
    logic    mul;
    logic    rmul;
    logic    push;
  } pts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go;
    logic wrap_ok;
    logic freq_ok;
    logic div_done;
  } pts_sts_t;

endpackage
`default_nettype wire

// ----- design/pts_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pts_div import pts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] dividend,
  input  wire logic [DIV_DW-1:0] divisor,
  output logic      [DIV_NW-1:0] quotient,
  output logic                   done
);

  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // trial subtract of the next bit
  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NW-2:0], fits};
      rem_r <= fits ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

// ----- design/pts_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer of one item: decode, tone fetch, divider steps, result hand-off.
// ----------------------------------------------------------------------------
module pts_ctrl import pts_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire pts_sts_t sts,
  output pts_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WRAP,
    ST_ENT,
    ST_DSTART,
    ST_DWAIT,
    ST_MUL,
    ST_RMUL,
    ST_PUSH
  } state_t;

  state_t  state_r;
  pts_op_t op_r;
  logic    out_valid_r;
  logic    push_ok;

  assign push_ok = !out_valid_r || !out_stall;

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_CLK_F;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_valid) state_r <= ST_EXEC;
        ST_EXEC: state_r <= sts.go ? ST_WRAP : ST_PUSH;
        ST_WRAP: if (sts.wrap_ok) state_r <= ST_ENT;
        ST_ENT: begin
          op_r    <= OP_CLK_F;
          state_r <= sts.freq_ok ? ST_DSTART : ST_PUSH;
        end
        ST_DSTART: state_r <= ST_DWAIT;
        ST_DWAIT: begin
          if (sts.div_done) begin
            case (op_r)
              OP_CLK_F:   begin op_r <= OP_PERIOD; state_r <= ST_RMUL;   end
              OP_CLK_PRE: begin op_r <= OP_PER_F;  state_r <= ST_DSTART; end
              OP_PER_F:   state_r <= ST_MUL;
              default:    state_r <= ST_PUSH;
            endcase
          end
        end
        ST_MUL: begin
          op_r    <= OP_DUTY;
          state_r <= ST_RMUL;
        end
        ST_RMUL: begin
          if (op_r == OP_PERIOD) begin
            op_r    <= OP_CLK_PRE;
            state_r <= ST_DSTART;
          end else begin
            state_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push_ok) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.div_op    = op_r;
    cmd.take      = (state_r == ST_IDLE) && in_valid;
    cmd.exec      = (state_r == ST_EXEC);
    cmd.ent       = (state_r == ST_ENT);
    cmd.div_start = (state_r == ST_DSTART);
    cmd.div_store = (state_r == ST_DWAIT) && sts.div_done;
    cmd.mul       = (state_r == ST_MUL);
    cmd.rmul      = (state_r == ST_RMUL);
    cmd.push      = (state_r == ST_PUSH) && push_ok;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- design/pts_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_dp
// Datapath: configuration, tone memory, player state, timer arithmetic.
// ----------------------------------------------------------------------------
module pts_dp import pts_pkg::*; #(
  parameter int TONE_DEPTH = 256,
  parameter int MAX_PERIOD = 60000,
  parameter int MAX_FREQ   = 20000
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CLK_W-1:0]     cfg_wdata,
  input  wire logic [1:0]           in_req_type,
  input  wire logic [7:0]           in_cmd_byte,
  input  wire logic [7:0]           in_tone_addr,
  input  wire logic [FREQ_W-1:0]    in_tone_freq_in,
  input  wire logic [FREQ_W-1:0]    in_tone_dur_in,
  input  wire pts_cmd_t             cmd,
  output pts_sts_t                  sts,
  output logic [15:0]               out_timer_prescale,
  output logic [15:0]               out_timer_reload,
  output logic [15:0]               out_timer_compare,
  output logic                      out_pwm_running,
  output logic                      out_tone_loaded,
  output logic [IDX_W-1:0]          out_tone_position,
  output logic [VOL_W-1:0]          out_volume_level
);

  localparam int AW  = (TONE_DEPTH > 1) ? $clog2(TONE_DEPTH) : 1;
  localparam int WAW = (AW + 1 > 10) ? AW + 1 : 10;

  // reciprocal of the period limit, exact for every clock rate quotient
  localparam int PER_SH = CLK_W + $clog2(MAX_PERIOD);
  localparam int RCP_W  = CLK_W + 2;
  localparam logic [RCP_W-1:0] PER_RCP =
    RCP_W'(((64'd1 << PER_SH) + 64'(MAX_PERIOD) - 64'd1) / 64'(MAX_PERIOD));

  // configuration
  logic [CLK_W-1:0] sys_clk_r;
  logic [7:0]       base_r [3];
  logic [IDX_W-1:0] cnt_r  [3];
  logic [IDX_W-1:0] cfg_cnt;

  // captured item
  logic [1:0]        req_r;
  logic [7:0]        cmdb_r;
  logic [7:0]        waddr_r;
  logic [FREQ_W-1:0] wfreq_r;
  logic [FREQ_W-1:0] wdur_r;

  // player state
  logic [31:0]       ms_r;
  logic [31:0]       end_r;
  logic [IDX_W-1:0]  idx_r;
  logic [7:0]        abase_r;
  logic [IDX_W-1:0]  acnt_r;
  logic [VOL_W-1:0]  vol_r;
  logic              paused_r;
  logic              running_r;
  logic [15:0]       psc_r;
  logic [15:0]       arr_r;
  logic [15:0]       ccr_r;
  logic              loaded_r;

  // tone fetch and arithmetic
  logic [WAW-1:0]    addr_r;
  logic [31:0]       mem [TONE_DEPTH];
  logic [31:0]       mem_q_r;
  logic [FREQ_W-1:0] freq_r;
  logic [CLK_W-1:0]  acc_r;
  logic [DIV_DW-1:0] pre_r;
  logic [15:0]       psc_t_r;
  logic [CLK_W-1:0]  per_r;
  logic [DUTY_W-1:0] prod_r;
  logic [CLK_W+RCP_W-1:0] per_prod;
  logic [DUTY_W+26:0]     duty_prod;
  logic [31:0]       ms_inc;
  logic [WAW-1:0]    waddr_ext;

  // divider
  logic [DIV_NW-1:0] div_n;
  logic [DIV_DW-1:0] div_d;
  logic [DIV_NW-1:0] div_q;
  logic              div_done;

  assign ms_inc    = ms_r + 32'd1;
  assign waddr_ext = WAW'(waddr_r);
  assign cfg_cnt   = (cfg_wdata[IDX_W-1:0] > CNT_MAX) ? CNT_MAX : cfg_wdata[IDX_W-1:0];

  // reciprocal multiplies for the constant divisions
  assign per_prod  = acc_r * PER_RCP;
  assign duty_prod = prod_r * DUTY_RCP;

  // status
  assign sts.go       = (req_r == REQ_TICK) && !paused_r && (ms_inc > end_r) &&
                        (idx_r < acnt_r);
  assign sts.wrap_ok  = (32'(addr_r) < 32'(TONE_DEPTH));
  assign sts.freq_ok  = (mem_q_r[15:0] != '0) &&
                        ({1'b0, mem_q_r[15:0]} <= 17'(MAX_FREQ));
  assign sts.div_done = div_done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_clk_r <= CLK_W'(8000000);
      for (int k = 0; k < 3; k++) begin
        base_r[k] <= '0;
        cnt_r[k]  <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYS_CLK: sys_clk_r <= cfg_wdata;
        CFG_S0_BASE: base_r[0] <= cfg_wdata[7:0];
        CFG_S0_CNT:  cnt_r[0]  <= cfg_cnt;
        CFG_S1_BASE: base_r[1] <= cfg_wdata[7:0];
        CFG_S1_CNT:  cnt_r[1]  <= cfg_cnt;
        CFG_S2_BASE: base_r[2] <= cfg_wdata[7:0];
        CFG_S2_CNT:  cnt_r[2]  <= cfg_cnt;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_r   <= in_req_type;
      cmdb_r  <= in_cmd_byte;
      waddr_r <= in_tone_addr;
      wfreq_r <= in_tone_freq_in;
      wdur_r  <= in_tone_dur_in;
    end
  end

  // tone memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && req_r == REQ_WRITE && 32'(waddr_r) < 32'(TONE_DEPTH)) begin
      mem[waddr_ext[AW-1:0]] <= {wdur_r, wfreq_r};
    end
    mem_q_r <= mem[addr_r[AW-1:0]];
  end

  // address wrap by repeated subtract
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      addr_r <= WAW'(abase_r) + WAW'(idx_r);
    end else if (!sts.wrap_ok) begin
      addr_r <= WAW'(32'(addr_r) - 32'(TONE_DEPTH));
    end
  end

  // divider operand select
  always_comb begin
    case (cmd.div_op)
      OP_CLK_F:   begin div_n = DIV_NW'(sys_clk_r); div_d = DIV_DW'(freq_r); end
      OP_CLK_PRE: begin div_n = DIV_NW'(sys_clk_r); div_d = pre_r;           end
      default:    begin div_n = DIV_NW'(acc_r);     div_d = DIV_DW'(freq_r); end
    endcase
  end

  pts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (div_q),
    .done     (div_done)
  );

  // player state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r      <= '0;
      end_r     <= '0;
      idx_r     <= '0;
      abase_r   <= '0;
      acnt_r    <= '0;
      vol_r     <= VOL_RESET;
      paused_r  <= 1'b0;
      running_r <= 1'b0;
      psc_r     <= '0;
      arr_r     <= '0;
      ccr_r     <= '0;
      loaded_r  <= 1'b0;
    end else begin
      if (cmd.take) loaded_r <= 1'b0;
      if (cmd.exec && req_r == REQ_TICK) ms_r <= ms_inc;
      if (cmd.exec && req_r == REQ_CMD) begin
        case (cmdb_r)
          CMD_SLOT0, CMD_SLOT1, CMD_SLOT2: begin
            running_r <= 1'b1;
            idx_r     <= '0;
            abase_r   <= (cmdb_r == CMD_SLOT0) ? base_r[0] :
                         (cmdb_r == CMD_SLOT1) ? base_r[1] : base_r[2];
            acnt_r    <= (cmdb_r == CMD_SLOT0) ? cnt_r[0] :
                         (cmdb_r == CMD_SLOT1) ? cnt_r[1] : cnt_r[2];
          end
          CMD_VOL_UP: if (vol_r < VOL_MAX) vol_r <= vol_r + VOL_STEP;
          CMD_VOL_DN: begin
            if (vol_r != '0) vol_r <= (vol_r < VOL_STEP) ? '0 : vol_r - VOL_STEP;
          end
          CMD_PAUSE: begin
            running_r <= 1'b0;
            paused_r  <= 1'b1;
          end
          CMD_RESUME: begin
            running_r <= 1'b1;
            paused_r  <= 1'b0;
          end
          default: ;
        endcase
      end
      // tone entry fetched
      if (cmd.ent) begin
        end_r    <= ms_r + 32'(mem_q_r[31:16]);
        idx_r    <= idx_r + 1'b1;
        loaded_r <= 1'b1;
        if (!sts.freq_ok) ccr_r <= '0;
      end
      // duty scaling commits the timer registers
      if (cmd.rmul && cmd.div_op == OP_DUTY) begin
        psc_r <= psc_t_r;
        arr_r <= (per_r == '0) ? '0 : 16'(per_r - 1'b1);
        ccr_r <= 16'(duty_prod >> DUTY_SH);
      end
    end
  end

  // arithmetic intermediates
  always_ff @(posedge clk) begin
    if (cmd.ent) freq_r <= mem_q_r[15:0];
    if (cmd.div_store) begin
      case (cmd.div_op)
        OP_CLK_F:   acc_r <= div_q[CLK_W-1:0];
        OP_CLK_PRE: acc_r <= div_q[CLK_W-1:0];
        OP_PER_F:   per_r <= div_q[CLK_W-1:0];
        default: ;
      endcase
    end
    // prescaler from the clock to frequency ratio
    if (cmd.rmul && cmd.div_op == OP_PERIOD) begin
      pre_r   <= DIV_DW'(per_prod >> PER_SH) + 1'b1;
      psc_t_r <= 16'(per_prod >> PER_SH);
    end
    // period stays below the period limit, so 16 bits carry it
    if (cmd.mul) prod_r <= DUTY_W'(vol_r) * DUTY_W'(per_r[15:0]);
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_timer_prescale <= psc_r;
      out_timer_reload   <= arr_r;
      out_timer_compare  <= ccr_r;
      out_pwm_running    <= running_r;
      out_tone_loaded    <= loaded_r;
      out_tone_position  <= idx_r;
      out_volume_level   <= vol_r;
    end
  end

endmodule
`default_nettype wire

// ----- design/pwm_tone_melody_sequencer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_tone_melody_sequencer_core
// Buzzer melody sequencer producing PWM timer register values.
// ----------------------------------------------------------------------------
// Takes one transaction at a time and returns one result transaction for it.
// Commands, tone memory writes and ticks that load no tone pass from decode
// straight to the result hand-off. A tick that loads a silent tone adds the
// tone fetch and the address wrap (one subtraction of the memory depth per
// step, a single one for the default depth when base plus index passes the
// end). A tick that loads a sounding tone adds as well three divisions on a
// shared one-bit-per-cycle divider of 27 bits, and two reciprocal multiplies
// for the constant divisions. A stalled result holds the block once the next
// transaction is ready to hand off.
// The tone memory powers up undefined; only written entries should be played.
module pwm_tone_melody_sequencer_core import pts_pkg::*; #(
  parameter int TONE_DEPTH = 256,
  parameter int MAX_PERIOD = 60000,
  parameter int MAX_FREQ   = 20000
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CLK_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_req_type,
  input  wire logic [7:0]           in_cmd_byte,
  input  wire logic [7:0]           in_tone_addr,
  input  wire logic [15:0]          in_tone_freq_in,
  input  wire logic [15:0]          in_tone_dur_in,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [15:0]               out_timer_prescale,
  output logic [15:0]               out_timer_reload,
  output logic [15:0]               out_timer_compare,
  output logic                      out_pwm_running,
  output logic                      out_tone_loaded,
  output logic [8:0]                out_tone_position,
  output logic [9:0]                out_volume_level
);

  pts_cmd_t cmd;
  pts_sts_t sts;

  // sequencer
  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  pts_dp #(
    .TONE_DEPTH (TONE_DEPTH),
    .MAX_PERIOD (MAX_PERIOD),
    .MAX_FREQ   (MAX_FREQ)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_req_type        (in_req_type),
    .in_cmd_byte        (in_cmd_byte),
    .in_tone_addr       (in_tone_addr),
    .in_tone_freq_in    (in_tone_freq_in),
    .in_tone_dur_in     (in_tone_dur_in),
    .cmd                (cmd),
    .sts                (sts),
    .out_timer_prescale (out_timer_prescale),
    .out_timer_reload   (out_timer_reload),
    .out_timer_compare  (out_timer_compare),
    .out_pwm_running    (out_pwm_running),
    .out_tone_loaded    (out_tone_loaded),
    .out_tone_position  (out_tone_position),
    .out_volume_level   (out_volume_level)
  );

endmodule
`default_nettype wire
